@@ rtl/partition_fit_allocator_macros.svh @@
// Assertion macros for the partition fit allocator.
// Included by files that check their own behavior; no other dependencies.
`ifndef PARTITION_FIT_ALLOCATOR_MACROS_SVH
`define PARTITION_FIT_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

`define PFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfa check failed");

`define PFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfa check failed");

`else

`define PFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define PFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/pfa_pkg.sv @@
// Shared types and constants for the partition fit allocator.
// No dependencies; used by the controller, datapath and top level.
package pfa_pkg;

    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_WIDTH_DEF = 16;

    localparam logic       MODE_LOAD    = 1'b0;
    localparam logic       MODE_REQUEST = 1'b1;

    localparam logic [1:0] STRAT_FIRST = 2'd0;
    localparam logic [1:0] STRAT_NEXT  = 2'd1;
    localparam logic [1:0] STRAT_BEST  = 2'd2;
    localparam logic [1:0] STRAT_WORST = 2'd3;

    localparam logic [1:0] CFG_STRATEGY    = 2'd0;
    localparam logic [1:0] CFG_BLOCK_COUNT = 2'd1;

    localparam logic [4:0] BLOCK_COUNT_RST = 5'd16;

    typedef struct packed {
        logic        mode;
        logic [3:0]  block_index;
        logic [15:0] amount;
    } pfa_in_t;

    typedef struct packed {
        logic        granted;
        logic [3:0]  block_number;
        logic [15:0] remaining;
    } pfa_out_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic issue;
        logic commit;
    } pfa_cmd_t;

    typedef struct packed {
        logic req_mode;
        logic n_zero;
        logic scan_last;
    } pfa_stat_t;

endpackage

@@ rtl/pfa_ctrl.sv @@
// Sequencer for the partition fit allocator: accepts items, runs the scan.
// Depends on pfa_pkg for the command and status structs.
module pfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pfa_pkg::pfa_stat_t stat,
    output pfa_pkg::pfa_cmd_t  cmd
);
    import pfa_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (stat.req_mode == MODE_LOAD)
                        state_next = ST_LOAD;
                    else if (stat.n_zero)
                        state_next = ST_COMMIT;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_LOAD:   state_next = ST_IDLE;
            ST_SCAN:
            begin
                if (stat.scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:  state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign cmd.accept = start && (state_reg == ST_IDLE);
    assign cmd.load   = (state_reg == ST_LOAD);
    assign cmd.issue  = (state_reg == ST_SCAN);
    assign cmd.commit = (state_reg == ST_COMMIT);

endmodule

@@ rtl/pfa_datapath.sv @@
// Datapath of the partition fit allocator: block table, scan, fit selection.
// Depends on pfa_pkg; driven by pfa_ctrl through command and status structs.
module pfa_datapath #(
    parameter int NUM_BLOCKS = pfa_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = pfa_pkg::SIZE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pfa_pkg::pfa_in_t   item,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [4:0]         cfg_data,
    input  pfa_pkg::pfa_cmd_t  cmd,
    output pfa_pkg::pfa_stat_t stat,
    output logic               done,
    output pfa_pkg::pfa_out_t  result
);
    import pfa_pkg::*;

    localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int NW = (CW > 5) ? CW : 5;
    localparam int XW = (SIZE_WIDTH > 16) ? SIZE_WIDTH : 16;
    localparam logic [XW-1:0] SIZE_MAX_X = XW'((33'(1) << SIZE_WIDTH) - 33'(1));

    logic [SIZE_WIDTH-1:0] mem [NUM_BLOCKS];

    logic [1:0]            strat_reg;
    logic [4:0]            bc_reg;
    logic [IW-1:0]         np_reg;
    logic [3:0]            idx_reg;
    logic [XW-1:0]         amt_reg;
    logic [CW-1:0]         k_reg;
    logic [IW-1:0]         j_reg;
    logic [SIZE_WIDTH-1:0] rd_data_reg;
    logic [IW-1:0]         rd_tag_reg;
    logic                  rd_vld_reg;
    logic                  found_reg;
    logic [IW-1:0]         pick_reg;
    logic [SIZE_WIDTH-1:0] best_reg;
    logic                  done_reg;
    pfa_out_t              res_reg;

    logic [NW-1:0]         bc_x;
    logic [CW-1:0]         n_eff;
    logic [IW-1:0]         start_pos;
    logic [IW-1:0]         j_next;
    logic                  idx_ok;
    logic [SIZE_WIDTH-1:0] ld_val;
    logic                  fits;
    logic                  take;
    logic [SIZE_WIDTH-1:0] new_rem;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [SIZE_WIDTH-1:0] wr_data;

    always_comb
    begin
        bc_x      = NW'(bc_reg);
        n_eff     = (bc_x > NW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : CW'(bc_x);
        start_pos = ((strat_reg == STRAT_NEXT) && (CW'(np_reg) < n_eff)) ? np_reg : '0;
        j_next    = ((CW'(j_reg) + CW'(1)) == n_eff) ? '0 : j_reg + IW'(1);
        idx_ok    = (32'(idx_reg) < NUM_BLOCKS);
        ld_val    = (amt_reg > SIZE_MAX_X) ? SIZE_WIDTH'(SIZE_MAX_X)
                                           : SIZE_WIDTH'(amt_reg);
        fits      = (XW'(rd_data_reg) >= amt_reg);
        take      = rd_vld_reg && fits &&
                    (!found_reg ||
                     ((strat_reg == STRAT_BEST) && (rd_data_reg < best_reg)) ||
                     ((strat_reg == STRAT_WORST) && (rd_data_reg > best_reg)));
        new_rem   = SIZE_WIDTH'(XW'(best_reg) - amt_reg);
        wr_en     = (cmd.load && idx_ok) || (cmd.commit && found_reg);
        wr_addr   = cmd.load ? IW'(idx_reg) : pick_reg;
        wr_data   = cmd.load ? ld_val : new_rem;
    end

    assign stat.req_mode  = item.mode;
    assign stat.n_zero    = (n_eff == '0);
    assign stat.scan_last = (k_reg == (n_eff - CW'(1)));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[j_reg];
        rd_tag_reg  <= j_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strat_reg <= STRAT_FIRST;
            bc_reg    <= BLOCK_COUNT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_STRATEGY:    strat_reg <= cfg_data[1:0];
                CFG_BLOCK_COUNT: bc_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            np_reg     <= '0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.issue;
            done_reg   <= cmd.load || cmd.commit;
            if (cmd.accept)
                found_reg <= 1'b0;
            else if (take)
                found_reg <= 1'b1;
            if (cmd.load && idx_ok)
                np_reg <= '0;
            else if (cmd.commit && found_reg && (strat_reg == STRAT_NEXT))
                np_reg <= pick_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg <= item.block_index;
            amt_reg <= XW'(item.amount);
            k_reg   <= '0;
            j_reg   <= start_pos;
        end
        else if (cmd.issue)
        begin
            k_reg <= k_reg + CW'(1);
            j_reg <= j_next;
        end
        if (take)
        begin
            pick_reg <= rd_tag_reg;
            best_reg <= rd_data_reg;
        end
        if (cmd.load)
        begin
            res_reg.granted      <= idx_ok;
            res_reg.block_number <= idx_ok ? idx_reg : 4'd0;
            res_reg.remaining    <= idx_ok ? 16'(ld_val) : 16'd0;
        end
        else if (cmd.commit)
        begin
            res_reg.granted      <= found_reg;
            res_reg.block_number <= found_reg ? 4'(pick_reg) : 4'd0;
            res_reg.remaining    <= found_reg ? 16'(new_rem) : 16'd0;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ rtl/partition_fit_allocator.sv @@
// Top level of the partition fit allocator: controller plus datapath.
// Depends on pfa_pkg, pfa_ctrl, pfa_datapath and the assertion macro header.
//
//   channel   handshake              payload
//   item      start / busy           item   (pfa_in_t)
//   result    done (one cycle)       result (pfa_out_t)
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load item passes through the load state; its done strobe is registered from it.
// A request scans n blocks, n = active block count: the block table has one
// read port, so the scan reads one stored size per cycle, then a drain and a commit.
// A request with no blocks in use skips the scan and is refused at commit.
// The next item is taken in the cycle the strobe is shown; results cannot stall.
// Reset clears control and strategy and sets the block count to 16; the block table is not cleared.
`include "partition_fit_allocator_macros.svh"

module partition_fit_allocator #(
    parameter int NUM_BLOCKS = pfa_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_WIDTH = pfa_pkg::SIZE_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pfa_pkg::pfa_in_t  item,
    output logic              done,
    output pfa_pkg::pfa_out_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [4:0]        cfg_data
);
    import pfa_pkg::*;

    pfa_cmd_t  cmd;
    pfa_stat_t stat;

    assign cfg_ready = 1'b1;

    pfa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    pfa_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

    `PFA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `PFA_ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy)
    `PFA_ASSERT_IMPLY(a_fall_done, clk, rst_n, $fell(busy), done)
    `PFA_ASSERT_IMPLY(a_refuse_zero, clk, rst_n, done && !result.granted,
                      (result.block_number == 4'd0) && (result.remaining == 16'd0))

endmodule
